// ----- design/edf_pkg.sv -----
// Shared types, codes and defaults for the escaped byte deframer.
package edf_pkg;

  localparam int BUFFER_DEPTH_DEF = 256;
  localparam int QUEUE_DEPTH_DEF  = 2;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_RX_MODE       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE_ENABLE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE_BYTE   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_XOR_MASK      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_HEAD_BYTE     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_TAIL_BYTE     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_FIXED_LENGTH  = 3'd6;

  typedef enum logic [1:0] {
    MODE_FRAME = 2'd0,
    MODE_FIXED = 2'd1,
    MODE_PLAIN = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_STORED  = 2'd0,
    ST_ESCAPE  = 2'd1,
    ST_IGNORED = 2'd2,
    ST_DROPPED = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0] rx_mode;
    logic       escape_enable;
    logic [7:0] escape_byte;
    logic [7:0] xor_mask;
    logic [7:0] head_byte;
    logic [7:0] tail_byte;
    logic [7:0] fixed_length;
  } cfg_t;

  // Item passed from the escape front end to the framing back end.
  typedef struct packed {
    logic       esc;
    logic [7:0] data;
  } tok_t;

  typedef struct packed {
    logic       stored;
    logic [7:0] write_index;
    logic [7:0] write_data;
    logic       frame_end;
    logic [8:0] fill_after;
    status_t    status;
  } res_t;

endpackage

// ----- design/edf_queue.sv -----
// Small first-in first-out queue of fixed-width items.
module edf_queue import edf_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ----- design/edf_front.sv -----
// Front end: accepts raw bytes and resolves escape sequences.
module edf_front import edf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output tok_t       tok
);

  logic escape_pending;
  logic escape_pending_next;
  logic is_escape;

  assign is_escape = cfg.escape_enable && (rx_byte == cfg.escape_byte) && !escape_pending;

  always_comb begin
    escape_pending_next = escape_pending;
    tok.esc  = 1'b0;
    tok.data = rx_byte;
    if (is_escape) begin
      tok.esc = 1'b1;
      escape_pending_next = 1'b1;
    end else if (cfg.escape_enable && escape_pending) begin
      tok.data = rx_byte ^ cfg.xor_mask;
      escape_pending_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
    end else if (accept) begin
      escape_pending <= escape_pending_next;
    end
  end

endmodule

// ----- design/edf_back.sv -----
// Back end: applies the framing mode and tracks the buffer fill count.
module edf_back import edf_pkg::*; #(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic fire,
  input  tok_t tok,
  output res_t res
);

  localparam int FW = $clog2(BUFFER_DEPTH + 1);
  localparam int XW = (FW > 9) ? FW : 9;

  logic          in_frame;
  logic          in_frame_next;
  logic [FW-1:0] fill_count;
  logic [FW-1:0] fill_count_next;
  logic [FW-1:0] fill_base;
  logic          framed;
  logic          closes;
  logic [XW-1:0] idx_x;
  logic [XW-1:0] fill_x;
  logic [XW-1:0] len_x;

  assign len_x  = XW'(cfg.fixed_length);
  assign fill_x = XW'(fill_count_next);

  always_comb begin
    in_frame_next   = in_frame;
    fill_count_next = fill_count;
    fill_base       = fill_count;
    framed          = 1'b0;
    closes          = 1'b0;
    idx_x           = '0;
    res.stored      = 1'b0;
    res.write_data  = '0;
    res.frame_end   = 1'b0;
    res.status      = ST_IGNORED;

    if (tok.esc) begin
      res.status = ST_ESCAPE;
    end else begin
      case (cfg.rx_mode)
        MODE_FRAME: begin
          if (tok.data == cfg.head_byte) begin
            fill_base     = '0;
            in_frame_next = 1'b1;
            framed        = 1'b1;
          end else if (in_frame) begin
            framed = 1'b1;
            closes = (tok.data == cfg.tail_byte);
          end
        end
        MODE_FIXED: begin
          if (cfg.fixed_length != '0) begin
            framed = 1'b1;
            if (!in_frame) begin
              fill_base     = '0;
              in_frame_next = 1'b1;
            end else begin
              closes = (XW'(fill_count) >= len_x);
            end
          end
        end
        MODE_PLAIN: begin
          if (fill_count < FW'(BUFFER_DEPTH)) begin
            idx_x           = XW'(fill_count);
            res.write_data  = tok.data;
            res.stored      = 1'b1;
            res.status      = ST_STORED;
            fill_count_next = fill_count + FW'(1);
          end else begin
            fill_count_next = '0;
            res.status      = ST_DROPPED;
          end
        end
        default: begin
          res.status = ST_IGNORED;
        end
      endcase

      if (framed) begin
        if (fill_base >= FW'(BUFFER_DEPTH)) begin
          // The frame no longer fits, so it is abandoned.
          in_frame_next   = 1'b0;
          fill_count_next = fill_base;
          res.status      = ST_DROPPED;
        end else begin
          idx_x           = XW'(fill_base);
          res.write_data  = tok.data;
          res.stored      = 1'b1;
          res.status      = ST_STORED;
          fill_count_next = fill_base + FW'(1);
          if (closes) begin
            res.frame_end = 1'b1;
            in_frame_next = 1'b0;
          end
        end
      end
    end

    res.write_index = idx_x[7:0];
    res.fill_after  = fill_x[8:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      fill_count <= '0;
    end else if (fire) begin
      in_frame   <= in_frame_next;
      fill_count <= fill_count_next;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FW'(BUFFER_DEPTH))
    else $error("fill count exceeds buffer depth");

  a_end_closes: assert property (@(posedge clk) disable iff (rst)
    fire && res.frame_end |=> !in_frame)
    else $error("frame still open after frame end");

  a_end_stored: assert property (@(posedge clk) disable iff (rst)
    fire && res.frame_end |-> res.stored && (res.status == ST_STORED))
    else $error("frame end without a stored byte");

  a_drop_keeps: assert property (@(posedge clk) disable iff (rst)
    fire && (res.status == ST_DROPPED) && (cfg.rx_mode != MODE_PLAIN)
      |=> !in_frame && $stable(fill_count))
    else $error("dropped byte changed the fill count or kept the frame");

endmodule

// ----- design/escaped_byte_deframer.sv -----
// Top level of the escaped byte deframer: configuration, front end, queues, back end.
//
//  channel   handshake                 payload
//  input     push / full               rx_byte
//  result    empty / pop               stored, write_index, write_data, frame_end,
//                                      fill_after, status
//  config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One item per cycle is sustained while the result queue has room; an accepted item
// moves from the middle queue through the back end into the result queue to be popped.
// Reset clears the escape, frame and fill state and loads register defaults.
// The middle queue lets the front end keep accepting while the back end waits for
// room in the result queue; full rises once the middle queue holds QUEUE_DEPTH items.
module escaped_byte_deframer import edf_pkg::*; #(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic [7:0]             rx_byte,
  output logic                   empty,
  input  logic                   pop,
  output logic                   stored,
  output logic [7:0]             write_index,
  output logic [7:0]             write_data,
  output logic                   frame_end,
  output logic [8:0]             fill_after,
  output logic [1:0]             status,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int TW = $bits(tok_t);
  localparam int RW = $bits(res_t);

  cfg_t          cfg;
  tok_t          front_tok;
  tok_t          mid_tok;
  logic [TW-1:0] mid_bits;
  logic          mid_empty;
  logic          accept;
  logic          fire;
  logic          out_full;
  res_t          back_res;
  res_t          out_res;
  logic [RW-1:0] out_bits;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rx_mode       <= MODE_PLAIN;
      cfg.escape_enable <= 1'b1;
      cfg.escape_byte   <= 8'd125;
      cfg.xor_mask      <= 8'd32;
      cfg.head_byte     <= 8'd126;
      cfg.tail_byte     <= 8'd127;
      cfg.fixed_length  <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RX_MODE:       cfg.rx_mode       <= cfg_data[1:0];
        REG_ESCAPE_ENABLE: cfg.escape_enable <= cfg_data[0];
        REG_ESCAPE_BYTE:   cfg.escape_byte   <= cfg_data;
        REG_XOR_MASK:      cfg.xor_mask      <= cfg_data;
        REG_HEAD_BYTE:     cfg.head_byte     <= cfg_data;
        REG_TAIL_BYTE:     cfg.tail_byte     <= cfg_data;
        REG_FIXED_LENGTH:  cfg.fixed_length  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign accept = push && !full;

  edf_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (accept),
    .rx_byte (rx_byte),
    .tok     (front_tok)
  );

  edf_queue #(.WIDTH(TW), .DEPTH(QUEUE_DEPTH)) u_mid_q (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_tok),
    .full      (full),
    .pop       (fire),
    .pop_data  (mid_bits),
    .empty     (mid_empty)
  );

  assign mid_tok = tok_t'(mid_bits);
  assign fire    = !mid_empty && !out_full;

  edf_back #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_back (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .fire (fire),
    .tok  (mid_tok),
    .res  (back_res)
  );

  edf_queue #(.WIDTH(RW), .DEPTH(QUEUE_DEPTH)) u_out_q (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .push_data (back_res),
    .full      (out_full),
    .pop       (pop),
    .pop_data  (out_bits),
    .empty     (empty)
  );

  assign out_res     = res_t'(out_bits);
  assign stored      = out_res.stored;
  assign write_index = out_res.write_index;
  assign write_data  = out_res.write_data;
  assign frame_end   = out_res.frame_end;
  assign fill_after  = out_res.fill_after;
  assign status      = out_res.status;

endmodule

// ----- tb/sv/escaped_byte_deframer_tb.sv -----
// Self-checking testbench for the escaped byte deframer: directed table, then randomized phases.
`timescale 1ns / 100ps

module escaped_byte_deframer_tb;
  import edf_pkg::*;

  localparam int DEPTH       = BUFFER_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;
  localparam logic [1:0] MODE_RESERVED = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum logic {ROW_REG, ROW_BYTE} row_kind_t;

  typedef struct {
    row_kind_t                kind;
    logic [CFG_INDEX_W-1:0]   idx;
    logic [7:0]               val;
    bit                       typed;
    res_t                     want;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   push = 1'b0;
  logic                   full;
  logic [7:0]             rx_byte = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic                   stored;
  logic [7:0]             write_index;
  logic [7:0]             write_data;
  logic                   frame_end;
  logic [8:0]             fill_after;
  logic [1:0]             status;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  escaped_byte_deframer dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .rx_byte(rx_byte),
    .empty(empty), .pop(pop),
    .stored(stored), .write_index(write_index), .write_data(write_data),
    .frame_end(frame_end), .fill_after(fill_after), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Register copy, loaded with the reset defaults.
  logic [1:0] cfg_mode   = MODE_PLAIN;
  logic       cfg_esc_en = 1'b1;
  logic [7:0] cfg_esc    = 8'd125;
  logic [7:0] cfg_mask   = 8'd32;
  logic [7:0] cfg_head   = 8'd126;
  logic [7:0] cfg_tail   = 8'd127;
  logic [7:0] cfg_len    = 8'd0;

  // Deframer state as seen from outside.
  logic esc_pend = 1'b0;
  logic in_frm   = 1'b0;
  int   fill     = 0;

  res_t expected_q[$];
  int   errors = 0;
  int   cycles = 0;
  int   items_sent = 0;
  int   results_seen = 0;
  int   frame_ends = 0;
  int   drops = 0;
  int   escapes = 0;
  int   regs_written = 0;
  int   hold_rx = 0;
  int   tx_calm = 0;
  int   rx_calm = 0;
  bit   rush = 1'b0;

  function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
    case (idx)
      REG_RX_MODE:       cfg_mode   = val[1:0];
      REG_ESCAPE_ENABLE: cfg_esc_en = val[0];
      REG_ESCAPE_BYTE:   cfg_esc    = val;
      REG_XOR_MASK:      cfg_mask   = val;
      REG_HEAD_BYTE:     cfg_head   = val;
      REG_TAIL_BYTE:     cfg_tail   = val;
      REG_FIXED_LENGTH:  cfg_len    = val;
      default: ;
    endcase
  endfunction

  // A byte that would land past the end of the buffer abandons the frame.
  function automatic void store_byte(input logic [7:0] b, inout res_t r);
    if (fill >= DEPTH) begin
      in_frm = 1'b0;
      r.status = ST_DROPPED;
    end else begin
      r.stored = 1'b1;
      r.write_index = fill[7:0];
      r.write_data = b;
      r.status = ST_STORED;
      fill++;
    end
  endfunction

  function automatic res_t deframe_byte(input logic [7:0] raw);
    res_t       r;
    logic [7:0] b;
    bit         last;
    r = '0;
    r.status = ST_IGNORED;
    b = raw;
    if (cfg_esc_en && b == cfg_esc && !esc_pend) begin
      esc_pend = 1'b1;
      r.status = ST_ESCAPE;
    end else begin
      if (cfg_esc_en && esc_pend) begin
        b = b ^ cfg_mask;
        esc_pend = 1'b0;
      end
      case (cfg_mode)
        MODE_FRAME: begin
          if (b == cfg_head) begin
            fill = 0;
            in_frm = 1'b1;
            store_byte(b, r);
          end else if (in_frm) begin
            store_byte(b, r);
            if (r.status == ST_STORED && b == cfg_tail) begin
              r.frame_end = 1'b1;
              in_frm = 1'b0;
            end
          end
        end
        MODE_FIXED: begin
          if (cfg_len != 0) begin
            if (!in_frm) begin
              fill = 0;
              in_frm = 1'b1;
              store_byte(b, r);
            end else begin
              last = (fill >= cfg_len);
              store_byte(b, r);
              if (last && r.status == ST_STORED) begin
                r.frame_end = 1'b1;
                in_frm = 1'b0;
              end
            end
          end
        end
        MODE_PLAIN: begin
          if (fill < DEPTH) begin
            store_byte(b, r);
          end else begin
            fill = 0;
            r.status = ST_DROPPED;
          end
        end
        default: ;
      endcase
    end
    r.fill_after = fill[8:0];
    return r;
  endfunction

  // Mostly random waits, with occasional runs of back-to-back items.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm = $urandom_range(10, 30);
    return $urandom_range(0, 12);
  endfunction

  function automatic row_t byte_row(input logic [7:0] b);
    row_t r;
    r.kind = ROW_BYTE;
    r.idx = '0;
    r.val = b;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic row_t checked_row(input logic [7:0] b, input logic st, input logic [7:0] wi,
                                       input logic [7:0] wd, input logic [8:0] fa,
                                       input status_t s);
    row_t r;
    r = byte_row(b);
    r.typed = 1'b1;
    r.want.stored = st;
    r.want.write_index = wi;
    r.want.write_data = wd;
    r.want.frame_end = 1'b0;
    r.want.fill_after = fa;
    r.want.status = s;
    return r;
  endfunction

  function automatic row_t reg_row(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
    row_t r;
    r = byte_row(val);
    r.kind = ROW_REG;
    r.idx = idx;
    return r;
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit typed, input res_t want);
    res_t pred;
    int   gap;
    push <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (full);
    pred = deframe_byte(b);
    expected_q.push_back(typed ? want : pred);
    items_sent++;
    @(negedge clk);
    gap = rush ? 0 : draw_wait(tx_calm);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Stops offering items and waits until every result has been taken.
  task automatic wait_idle();
    push <= 1'b0;
    do @(negedge clk); while (expected_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    regs_written++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_regs(input logic [1:0] mode, input logic en, input logic [7:0] esc,
                          input logic [7:0] mask, input logic [7:0] head,
                          input logic [7:0] tail, input logic [7:0] len);
    wait_idle();
    write_reg(REG_RX_MODE, {6'd0, mode});
    write_reg(REG_ESCAPE_ENABLE, {7'd0, en});
    write_reg(REG_ESCAPE_BYTE, esc);
    write_reg(REG_XOR_MASK, mask);
    write_reg(REG_HEAD_BYTE, head);
    write_reg(REG_TAIL_BYTE, tail);
    write_reg(REG_FIXED_LENGTH, len);
  endtask

  // Payload never carries the head or tail value; escapes are inserted at random.
  task automatic send_payload();
    logic [7:0] v;
    do v = $urandom_range(0, 255); while (v == cfg_head || v == cfg_tail);
    if (cfg_esc_en && (v == cfg_esc || $urandom_range(0, 7) == 0)) begin
      send_byte(cfg_esc, 1'b0, '0);
      send_byte(v ^ cfg_mask, 1'b0, '0);
    end else begin
      send_byte(v, 1'b0, '0);
    end
  endtask

  task automatic send_frame(input int len);
    send_byte(cfg_head, 1'b0, '0);
    repeat (len) send_payload();
    send_byte(cfg_tail, 1'b0, '0);
  endtask

  task automatic send_noise(input int n);
    logic [7:0] v;
    repeat (n) begin
      v = ($urandom_range(0, 5) == 0) ? cfg_esc : 8'($urandom_range(0, 255));
      send_byte(v, 1'b0, '0);
    end
  endtask

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  task automatic check_result();
    res_t want;
    if (expected_q.size() == 0) begin
      $display("%0t ns: result with no item pending, status %0d fill %0d",
               $time, status, fill_after);
      errors++;
    end else begin
      want = expected_q.pop_front();
      check_field("stored", want.stored, stored);
      check_field("write_index", want.write_index, write_index);
      check_field("write_data", want.write_data, write_data);
      check_field("frame_end", want.frame_end, frame_end);
      check_field("fill_after", want.fill_after, fill_after);
      check_field("status", want.status, status);
      results_seen++;
      if (want.frame_end) frame_ends++;
      if (want.status == ST_DROPPED) drops++;
      if (want.status == ST_ESCAPE) escapes++;
    end
  endtask

  // Result side; a requested hold-off is counted here, on top of the random wait.
  initial begin
    int wait_n;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      wait_n = draw_wait(rx_calm) + hold_rx;
      hold_rx = 0;
      if (wait_n > 0) begin
        pop <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      check_result();
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t ns: no finish after %0d cycles, %0d results outstanding",
               $time, CYCLE_LIMIT, expected_q.size());
      $display("escaped_byte_deframer regression: fail");
      $finish;
    end
  end

  initial begin
    row_t       plan[$];
    logic [7:0] h;
    logic [7:0] e;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Defaults after reset: plain fill, escape 0x7d, mask 0x20, head 0x7e, tail 0x7f.
    plan.push_back(checked_row(8'h00, 1'b1, 8'd0, 8'h00, 9'd1, ST_STORED));
    plan.push_back(checked_row(8'hFF, 1'b1, 8'd1, 8'hFF, 9'd2, ST_STORED));
    plan.push_back(checked_row(8'h7D, 1'b0, 8'd0, 8'h00, 9'd2, ST_ESCAPE));
    // An escape byte right after an escape is unescaped like any other byte.
    plan.push_back(checked_row(8'h7D, 1'b1, 8'd2, 8'h5D, 9'd3, ST_STORED));
    plan.push_back(byte_row(8'h7D));
    plan.push_back(byte_row(8'h5E));
    // A pending escape survives a stretch with escaping turned off.
    plan.push_back(byte_row(8'h7D));
    plan.push_back(reg_row(REG_ESCAPE_ENABLE, 8'd0));
    plan.push_back(byte_row(8'h7D));
    plan.push_back(reg_row(REG_ESCAPE_ENABLE, 8'd1));
    plan.push_back(byte_row(8'h41));
    plan.push_back(reg_row(REG_RX_MODE, {6'd0, MODE_FRAME}));
    plan.push_back(checked_row(8'h41, 1'b0, 8'd0, 8'h00, 9'd6, ST_IGNORED));
    plan.push_back(checked_row(8'h7E, 1'b1, 8'd0, 8'h7E, 9'd1, ST_STORED));
    plan.push_back(byte_row(8'h41));
    plan.push_back(byte_row(8'h7D));
    plan.push_back(byte_row(8'h5F));
    plan.push_back(byte_row(8'h7F));
    // Head and tail equal: the byte counts as a head every time.
    plan.push_back(reg_row(REG_TAIL_BYTE, 8'h7E));
    plan.push_back(byte_row(8'h7E));
    plan.push_back(byte_row(8'h7E));
    plan.push_back(reg_row(REG_RX_MODE, {6'd0, MODE_FIXED}));
    plan.push_back(byte_row(8'h33));
    plan.push_back(reg_row(REG_FIXED_LENGTH, 8'd2));
    plan.push_back(byte_row(8'h10));
    plan.push_back(byte_row(8'h11));
    plan.push_back(byte_row(8'h12));
    plan.push_back(byte_row(8'h13));
    plan.push_back(reg_row(REG_RX_MODE, {6'd0, MODE_RESERVED}));
    plan.push_back(byte_row(8'hAA));
    plan.push_back(reg_row(REG_UNUSED, 8'hFF));
    plan.push_back(byte_row(8'h55));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        wait_idle();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_byte(plan[i].val, plan[i].typed, plan[i].want);
      end
    end

    // A frame is opened, plain fill brings the buffer near its end, and the frame
    // then overruns it; plain fill afterwards wraps the full buffer. Escaping is off.
    set_regs(MODE_FRAME, 1'b0, 8'h00, 8'h00, 8'h01, 8'h02, 8'd0);
    send_byte(cfg_head, 1'b0, '0);
    wait_idle();
    write_reg(REG_RX_MODE, {6'd0, MODE_PLAIN});
    send_noise(250);
    wait_idle();
    write_reg(REG_RX_MODE, {6'd0, MODE_FRAME});
    repeat (8) send_payload();
    wait_idle();
    write_reg(REG_RX_MODE, {6'd0, MODE_PLAIN});
    send_noise(3);

    // Frames with extreme head and tail; one frame is pushed against a stalled receiver.
    e = $urandom_range(1, 254);
    set_regs(MODE_FRAME, 1'b1, e, 8'hFF, 8'h00, 8'hFF, 8'd0);
    for (int k = 0; k < 8; k++) begin
      if (k == 4) begin
        hold_rx = HOLD_CYCLES;
        rush = 1'b1;
        send_frame(20);
        rush = 1'b0;
      end else begin
        send_frame($urandom_range(0, 10));
      end
      if ($urandom_range(0, 3) == 0) send_noise($urandom_range(1, 3));
    end

    // Fixed length at the top of its range, then short and zero lengths.
    set_regs(MODE_FIXED, 1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
             8'd255);
    send_noise(20);
    wait_idle();
    write_reg(REG_FIXED_LENGTH, 8'd1);
    send_noise(15);
    repeat (4) begin
      wait_idle();
      write_reg(REG_FIXED_LENGTH, 8'($urandom_range(0, 8)));
      send_noise(8);
    end

    // Head equal to tail, zero mask.
    h = $urandom;
    do e = $urandom; while (e == h);
    set_regs(MODE_FRAME, 1'($urandom), e, 8'h00, h, h, 8'($urandom));
    repeat (4) begin
      send_frame($urandom_range(0, 6));
      send_noise($urandom_range(0, 3));
    end

    wait_idle();
    write_reg(REG_RX_MODE, {6'd0, MODE_RESERVED});
    send_noise(10);

    wait_idle();
    repeat (10) @(posedge clk);
    $display("run covered %0d bytes and %0d checked results: %0d frame ends, %0d drops, %0d escapes",
             items_sent, results_seen, frame_ends, drops, escapes);
    $display("%0d register writes over plain, frame, fixed and reserved modes", regs_written);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("escaped_byte_deframer regression: pass");
    end else begin
      $display("escaped_byte_deframer regression: fail");
    end
    $finish;
  end

endmodule
